>>> rtl/core/fba_pkg.sv
package fba_pkg;

	localparam int MAX_WORDS_DEFAULT     = 32;
	localparam int BITS_PER_WORD_DEFAULT = 32;

	localparam int FRAME_W    = 10;
	localparam int FRAME_LIMIT = 1 << FRAME_W;
	localparam int CMD_W      = 2;
	localparam int WIU_W      = 6;

	localparam logic [WIU_W-1:0] WIU_RESET = 6'd32;

	typedef enum logic [CMD_W-1:0] {
		CMD_ALLOC = 2'd0,
		CMD_FREE  = 2'd1,
		CMD_TEST  = 2'd2,
		CMD_NONE  = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_READ,
		S_WRITE
	} state_t;

	typedef struct packed {
		logic en;
		logic full;
	} full_upd_t;

endpackage

>>> rtl/core/fba_bitmap_mem.sv
module fba_bitmap_mem #(
	parameter int MAX_WORDS     = fba_pkg::MAX_WORDS_DEFAULT,
	parameter int BITS_PER_WORD = fba_pkg::BITS_PER_WORD_DEFAULT,
	parameter int WAW           = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     rd_en,
	input  logic [WAW-1:0]           rd_addr,
	output logic [BITS_PER_WORD-1:0] rd_data,
	input  logic                     wr_en,
	input  logic [WAW-1:0]           wr_addr,
	input  logic [BITS_PER_WORD-1:0] wr_data
);

	logic [BITS_PER_WORD-1:0] mem_q [MAX_WORDS];
	logic [MAX_WORDS-1:0]     vld_q;
	logic [BITS_PER_WORD-1:0] rd_data_q;
	logic                     rd_vld_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (wr_en) begin
				vld_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				rd_vld_q <= vld_q[rd_addr];
			end
		end
	end

	assign rd_data = rd_vld_q ? rd_data_q : '0;

endmodule

>>> rtl/core/fba_word_scan.sv
module fba_word_scan #(
	parameter int MAX_WORDS = fba_pkg::MAX_WORDS_DEFAULT,
	parameter int WAW       = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic [fba_pkg::WIU_W-1:0]      limit,
	input  fba_pkg::full_upd_t             upd,
	input  logic [WAW-1:0]                 upd_word,
	output logic                           hit,
	output logic [WAW-1:0]                 hit_word
);

	logic [MAX_WORDS-1:0] full_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			full_q <= '0;
		end else if (upd.en) begin
			full_q[upd_word] <= upd.full;
		end
	end

	// lowest word below the limit that still has a clear bit
	always_comb begin
		hit      = 1'b0;
		hit_word = '0;
		for (int w = MAX_WORDS - 1; w >= 0; w--) begin
			if (!full_q[w] && (32'(w) < 32'(limit))) begin
				hit      = 1'b1;
				hit_word = WAW'(w);
			end
		end
	end

endmodule

>>> rtl/core/frame_bitmap_allocator.sv
// Frame bitmap allocator: one used bit per physical frame, held in a
// MAX_WORDS x BITS_PER_WORD synchronous memory that reads as all zero after
// reset (per-word valid bits, so no clearing pass). Send cmd on s_tuser
// (0 allocate, 1 free, 2 test) and the frame number on s_tdata; each item
// returns exactly one result on m_tdata. An accepted item reads the memory,
// then modifies and writes back its word and registers its result; the
// next item is accepted in that write step, while results are taken, as
// each owns the memory read-modify-write. Allocate picks the
// lowest clear bit in the first words_in_use words, using a per-word full
// vector to choose the word. Write words_in_use on the cfg channel only
// while no item is in flight.
module frame_bitmap_allocator #(
	parameter int MAX_WORDS     = fba_pkg::MAX_WORDS_DEFAULT,
	parameter int BITS_PER_WORD = fba_pkg::BITS_PER_WORD_DEFAULT
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      s_tvalid,
	output logic                      s_tready,
	input  logic [15:0]               s_tdata,   // [9:0] frame_index
	input  logic [1:0]                s_tuser,   // [1:0] cmd
	output logic                      m_tvalid,
	input  logic                      m_tready,
	output logic [15:0]               m_tdata,   // [9:0] allocated_frame, [10] status,
	                                             // [11] frame_in_use
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic [fba_pkg::WIU_W-1:0] cfg_data
);

	localparam int FW    = fba_pkg::FRAME_W;
	localparam int WAW   = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;
	localparam int BAW   = $clog2(BITS_PER_WORD);
	localparam int RK    = FW + 1;
	localparam int RECIP = (1 << RK) / BITS_PER_WORD;
	localparam int RW    = RK - 2;
	localparam int PW    = FW + RW;
	localparam int AW    = WAW + BAW;

	fba_pkg::state_t state_q, state_d;

	logic [fba_pkg::WIU_W-1:0] wiu_q;
	logic                      in_acc;
	logic                      go;
	logic                      out_free;

	fba_pkg::cmd_t cmd_s1;
	logic [FW-1:0] frame_s1;
	logic [FW-1:0] q_s1;
	logic [PW-1:0] prod;

	logic [FW:0]    qb;
	logic [FW:0]    rem;
	logic [FW-1:0]  q_fix;
	logic [BAW-1:0] rem_fix;
	logic           in_range;

	logic           scan_hit;
	logic [WAW-1:0] scan_word;
	logic [WAW-1:0] rd_addr;
	logic           rd_ok;

	fba_pkg::cmd_t  cmd_s2;
	logic [WAW-1:0] word_s2;
	logic [BAW-1:0] bit_s2;
	logic           ok_s2;

	logic [BITS_PER_WORD-1:0] rd_data;
	logic [BITS_PER_WORD-1:0] sel;
	logic [BITS_PER_WORD-1:0] set_word;
	logic [BITS_PER_WORD-1:0] wr_data;
	logic [BAW-1:0]           zbit;
	logic [AW-1:0]            f_alloc;
	logic                     fits;
	logic                     now_full;
	logic                     wr_en;
	fba_pkg::full_upd_t       upd;

	logic          out_valid_q;
	logic [FW-1:0] alloc_q;
	logic          status_q;
	logic          in_use_q;

	assign cfg_ready = 1'b1;
	assign out_free  = !out_valid_q || m_tready;
	assign in_acc    = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wiu_q <= fba_pkg::WIU_RESET;
		end else if (cfg_valid) begin
			wiu_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= fba_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		go       = 1'b0;
		s_tready = 1'b0;
		case (state_q)
			fba_pkg::S_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					state_d = fba_pkg::S_READ;
				end
			end
			fba_pkg::S_READ: begin
				state_d = fba_pkg::S_WRITE;
			end
			fba_pkg::S_WRITE: begin
				go       = out_free;
				s_tready = out_free;
				if (out_free) begin
					state_d = s_tvalid ? fba_pkg::S_READ : fba_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = fba_pkg::S_IDLE;
			end
		endcase
	end

	// word index by reciprocal multiply, corrected in the read cycle
	assign prod = PW'(s_tdata[FW-1:0]) * PW'(RECIP);

	always_ff @(posedge clk) begin
		if (in_acc) begin
			cmd_s1   <= fba_pkg::cmd_t'(s_tuser);
			frame_s1 <= s_tdata[FW-1:0];
			q_s1     <= FW'(prod >> RK);
		end
	end

	always_comb begin
		qb  = (FW+1)'(q_s1) * (FW+1)'(BITS_PER_WORD);
		rem = (FW+1)'(frame_s1) - qb;
		if (rem >= (FW+1)'(BITS_PER_WORD)) begin
			q_fix   = q_s1 + FW'(1);
			rem_fix = BAW'(rem - (FW+1)'(BITS_PER_WORD));
		end else begin
			q_fix   = q_s1;
			rem_fix = BAW'(rem);
		end
		in_range = 32'(q_fix) < 32'(MAX_WORDS);
		if (cmd_s1 == fba_pkg::CMD_ALLOC) begin
			rd_addr = scan_word;
			rd_ok   = scan_hit;
		end else begin
			rd_addr = WAW'(q_fix);
			rd_ok   = in_range;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == fba_pkg::S_READ) begin
			cmd_s2  <= cmd_s1;
			word_s2 <= rd_addr;
			bit_s2  <= rem_fix;
			ok_s2   <= rd_ok;
		end
	end

	fba_word_scan #(
		.MAX_WORDS (MAX_WORDS),
		.WAW       (WAW)
	) u_scan (
		.clk      (clk),
		.arst_n   (arst_n),
		.limit    (wiu_q),
		.upd      (upd),
		.upd_word (word_s2),
		.hit      (scan_hit),
		.hit_word (scan_word)
	);

	fba_bitmap_mem #(
		.MAX_WORDS     (MAX_WORDS),
		.BITS_PER_WORD (BITS_PER_WORD),
		.WAW           (WAW)
	) u_mem (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (state_q == fba_pkg::S_READ),
		.rd_addr (rd_addr),
		.rd_data (rd_data),
		.wr_en   (wr_en),
		.wr_addr (word_s2),
		.wr_data (wr_data)
	);

	always_comb begin
		zbit = '0;
		for (int j = BITS_PER_WORD - 1; j >= 0; j--) begin
			if (!rd_data[j]) begin
				zbit = BAW'(j);
			end
		end
	end

	always_comb begin
		f_alloc  = AW'(word_s2) * AW'(BITS_PER_WORD) + AW'(zbit);
		fits     = 32'(f_alloc) < 32'(fba_pkg::FRAME_LIMIT);
		sel      = BITS_PER_WORD'(1) << ((cmd_s2 == fba_pkg::CMD_ALLOC) ? zbit : bit_s2);
		set_word = rd_data | sel;
		now_full = &set_word;
		wr_en    = 1'b0;
		wr_data  = set_word;
		upd.en   = 1'b0;
		upd.full = 1'b0;
		case (cmd_s2)
			fba_pkg::CMD_ALLOC: begin
				wr_en    = go && ok_s2 && fits;
				upd.full = now_full;
			end
			fba_pkg::CMD_FREE: begin
				wr_en   = go && ok_s2;
				wr_data = rd_data & ~sel;
			end
			default: begin
				wr_en = 1'b0;
			end
		endcase
		upd.en = wr_en;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (go) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			alloc_q  <= (cmd_s2 == fba_pkg::CMD_ALLOC && ok_s2 && fits) ? FW'(f_alloc) : '0;
			status_q <= (cmd_s2 == fba_pkg::CMD_ALLOC) && !(ok_s2 && fits);
			in_use_q <= (cmd_s2 == fba_pkg::CMD_TEST) && ok_s2 && rd_data[bit_s2];
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {4'b0, in_use_q, status_q, alloc_q};

endmodule

>>> verif/testbench.sv
`timescale 1ns / 100ps

module testbench;
	import fba_pkg::*;

	localparam int MAP_WORDS = MAX_WORDS_DEFAULT;
	localparam int WORD_BITS = BITS_PER_WORD_DEFAULT;
	localparam int PHASE_ITEMS = 265;

	// [9:0] allocated_frame, [10] status (no free frame), [11] frame_in_use
	typedef struct packed {
		logic           in_use;
		logic           no_free;
		logic [FRAME_W-1:0] frame;
	} fba_result_t;

	typedef struct packed {
		cmd_t           op;
		logic [FRAME_W-1:0] frame;
		logic           fixed;
		fba_result_t    want;
	} probe_t;

	localparam probe_t PROBES [20] = '{
		'{CMD_ALLOC, 10'd0,    1'b1, 12'h000},
		'{CMD_ALLOC, 10'd0,    1'b1, 12'h001},
		'{CMD_TEST,  10'd0,    1'b1, 12'h800},
		'{CMD_TEST,  10'd1023, 1'b1, 12'h000},
		'{CMD_FREE,  10'd0,    1'b1, 12'h000},
		'{CMD_TEST,  10'd0,    1'b1, 12'h000},
		'{CMD_ALLOC, 10'd1023, 1'b1, 12'h000},
		'{CMD_FREE,  10'd1023, 1'b1, 12'h000},
		'{CMD_TEST,  10'd1023, 1'b1, 12'h000},
		'{CMD_NONE,  10'd1023, 1'b1, 12'h000},
		'{CMD_NONE,  10'd0,    1'b1, 12'h000},
		'{CMD_FREE,  10'd1,    1'b1, 12'h000},
		'{CMD_FREE,  10'd1,    1'b1, 12'h000},
		'{CMD_ALLOC, 10'd0,    1'b1, 12'h001},
		'{CMD_TEST,  10'd1,    1'b1, 12'h800},
		'{CMD_ALLOC, 10'd1023, 1'b1, 12'h002},
		'{CMD_FREE,  10'd512,  1'b0, 12'h000},
		'{CMD_TEST,  10'd682,  1'b0, 12'h000},
		'{CMD_TEST,  10'd341,  1'b0, 12'h000},
		'{CMD_ALLOC, 10'd0,    1'b0, 12'h000}
	};

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               s_tvalid = 1'b0;
	logic               s_tready;
	logic [15:0]        s_tdata = '0;   // [9:0] frame_index
	logic [1:0]         s_tuser = '0;   // [1:0] cmd
	logic               m_tvalid;
	logic               m_tready = 1'b0;
	logic [15:0]        m_tdata;        // [9:0] allocated_frame, [10] status, [11] frame_in_use
	logic               cfg_valid = 1'b0;
	logic               cfg_ready;
	logic [WIU_W-1:0]   cfg_data = '0;

	logic [WORD_BITS-1:0] used_map [MAP_WORDS];
	logic [WIU_W-1:0]     search_words;
	fba_result_t          pending_results [$];
	logic [FRAME_W-1:0]   held_frames [$];
	int                   mismatches = 0;
	int                   stall_left = 0;
	logic                 steady = 1'b0;

	frame_bitmap_allocator DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	initial begin
		#10_000_000;
		$display("CHECKS FAILED");
		$finish;
	end

	function automatic fba_result_t frame_map_apply(cmd_t op, logic [FRAME_W-1:0] frame);
		fba_result_t r;
		int          limit;
		logic        found;
		r = '0;
		found = 1'b0;
		case (op)
			CMD_ALLOC: begin
				limit = (int'(search_words) > MAP_WORDS) ? MAP_WORDS : int'(search_words);
				for (int w = 0; w < limit && !found; w++)
					for (int b = 0; b < WORD_BITS && !found; b++)
						if (!used_map[w][b] && (w * WORD_BITS + b) < FRAME_LIMIT) begin
							found = 1'b1;
							used_map[w][b] = 1'b1;
							r.frame = FRAME_W'(w * WORD_BITS + b);
						end
				r.no_free = !found;
			end
			CMD_FREE: begin
				if (int'(frame) / WORD_BITS < MAP_WORDS)
					used_map[int'(frame) / WORD_BITS][int'(frame) % WORD_BITS] = 1'b0;
			end
			CMD_TEST: begin
				if (int'(frame) / WORD_BITS < MAP_WORDS)
					r.in_use = used_map[int'(frame) / WORD_BITS][int'(frame) % WORD_BITS];
			end
			default: ;
		endcase
		return r;
	endfunction

	task automatic send_op(input cmd_t op, input logic [FRAME_W-1:0] frame, input logic fixed,
			input fba_result_t want, output fba_result_t got);
		int gap;
		if (!steady && $urandom_range(0, 5) == 0) begin
			gap = $urandom_range(1, 9);
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= op;
		s_tdata <= {6'd0, frame};
		do @(posedge clk); while (!s_tready);
		got = frame_map_apply(op, frame);
		pending_results.push_back(fixed ? want : got);
	endtask

	task automatic drain(input int extra);
		s_tvalid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (extra) @(posedge clk);
	endtask

	task automatic write_search_words(input logic [WIU_W-1:0] value);
		cfg_valid <= 1'b1;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		search_words = value;
	endtask

	always @(posedge clk) begin : result_check
		fba_result_t want;
		if (arst_n && m_tvalid === 1'b1 && m_tready) begin
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected item, expected none, got %h", $time, m_tdata);
				mismatches++;
			end else begin
				want = pending_results.pop_front();
				if (m_tdata[9:0] !== want.frame) begin
					$display("%0t: allocated_frame expected %0d got %0d",
						$time, want.frame, m_tdata[9:0]);
					mismatches++;
				end
				if (m_tdata[10] !== want.no_free) begin
					$display("%0t: status expected %0d got %0d", $time, want.no_free, m_tdata[10]);
					mismatches++;
				end
				if (m_tdata[11] !== want.in_use) begin
					$display("%0t: frame_in_use expected %0d got %0d",
						$time, want.in_use, m_tdata[11]);
					mismatches++;
				end
			end
		end
		if (steady) begin
			m_tready <= 1'b1;
		end else if (stall_left > 0) begin
			m_tready <= 1'b0;
			stall_left--;
		end else if ($urandom_range(0, 5) == 0) begin
			m_tready <= 1'b0;
			stall_left = $urandom_range(0, 8);
		end else begin
			m_tready <= 1'b1;
		end
	end

	initial begin : stimulus
		fba_result_t        got;
		cmd_t               op;
		logic [FRAME_W-1:0] frame;
		logic [WIU_W-1:0]   settings [6];
		int                 pick;
		int                 k;
		for (int w = 0; w < MAP_WORDS; w++)
			used_map[w] = '0;
		search_words = WIU_RESET;
		settings[0] = 6'd1;
		settings[1] = 6'd0;
		settings[2] = 6'd2;
		settings[3] = 6'd63;
		settings[4] = WIU_W'($urandom_range(3, 31));
		settings[5] = 6'd32;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (PROBES[i])
			send_op(PROBES[i].op, PROBES[i].frame, PROBES[i].fixed, PROBES[i].want, got);

		for (int p = 0; p < 6; p++) begin
			drain(4);
			if (p == 5)
				steady = 1'b1;
			write_search_words(settings[p]);
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				if (n == PHASE_ITEMS / 2)
					drain(0);
				pick = $urandom_range(0, 99);
				if (pick < 45)
					op = CMD_ALLOC;
				else if (pick < 70)
					op = CMD_FREE;
				else if (pick < 95)
					op = CMD_TEST;
				else
					op = CMD_NONE;
				frame = FRAME_W'($urandom_range(0, FRAME_LIMIT - 1));
				if ((op == CMD_FREE || op == CMD_TEST) && held_frames.size() != 0
						&& $urandom_range(0, 1) == 1) begin
					k = $urandom_range(0, held_frames.size() - 1);
					frame = held_frames[k];
					if (op == CMD_FREE)
						held_frames.delete(k);
				end
				send_op(op, frame, 1'b0, '0, got);
				if (op == CMD_ALLOC && !got.no_free)
					held_frames.push_back(got.frame);
			end
		end

		drain(8);
		if (mismatches == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
